@@ rtl/assert_macros.svh @@
// Assertion macros used by the encoder's bit packer.
// Depends on nothing; each use names its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/ecgdh_pkg.sv @@
// Types and constants for the ECG default Huffman encoder.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package ecgdh_pkg;

  localparam int CODE_W = 26;   // longest code: nine ones, size bit, 16-bit payload
  localparam int LEN_W  = 5;
  localparam int PEND_W = 7;    // bits carried between samples
  localparam int ACC_W  = CODE_W + PEND_W;
  localparam int CNT_W  = 6;

  localparam logic [1:0] ORDER_RAW    = 2'd0;
  localparam logic [1:0] ORDER_FIRST  = 2'd1;
  localparam logic [1:0] ORDER_SECOND = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // one classified sample, right-aligned code
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } code_entry_t;

endpackage

`default_nettype wire

@@ rtl/ecgdh_front.sv @@
// Front end: difference former and code classifier, holds diff_order and history.
// Depends on ecgdh_pkg.
`default_nettype none

module ecgdh_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ecgdh_pkg::in_item_t in_data,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output ecgdh_pkg::code_entry_t   push_data
);

  logic [1:0]         diff_order_r;
  logic signed [15:0] prev_r, prev_nxt;
  logic signed [15:0] pprev_r, pprev_nxt;
  logic [1:0]         seen_r, seen_nxt;
  logic signed [15:0] raw_d;
  logic signed [15:0] d;
  logic signed [15:0] abs_d;
  logic [3:0]         mag;
  logic [8:0]         ones;
  logic               accept;

  assign accept     = in_valid && in_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    if (diff_order_r == ecgdh_pkg::ORDER_FIRST && seen_r != 2'd0) begin
      raw_d = in_data.sample - prev_r;
    end else if (diff_order_r == ecgdh_pkg::ORDER_SECOND && seen_r == 2'd2) begin
      raw_d = in_data.sample - (prev_r <<< 1) + pprev_r;
    end else begin
      raw_d = in_data.sample;
    end
    // most negative value folds onto the most positive
    d     = (raw_d == 16'sh8000) ? 16'sh7FFF : raw_d;
    abs_d = d[15] ? -d : d;
    mag   = abs_d[3:0];
    ones  = (9'd1 << mag) - 9'd1;

    push_data.last = in_data.end_of_block;
    if (d == 16'sd0) begin
      push_data.code = '0;
      push_data.len  = 5'd1;
    end else if (d >= -16'sd8 && d <= 16'sd8) begin
      push_data.code = {16'b0, ones[7:0], 1'b0, d[15]};
      push_data.len  = {1'b0, mag} + 5'd2;
    end else if (d >= -16'sd128 && d <= 16'sd127) begin
      push_data.code = {8'b0, 9'h1FF, 1'b0, d[7:0]};
      push_data.len  = 5'd18;
    end else begin
      push_data.code = {9'h1FF, 1'b1, d};
      push_data.len  = 5'd26;
    end
  end

  always_comb begin
    prev_nxt  = prev_r;
    pprev_nxt = pprev_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (in_data.end_of_block) begin
        prev_nxt  = '0;
        pprev_nxt = '0;
        seen_nxt  = 2'd0;
      end else begin
        prev_nxt  = in_data.sample;
        pprev_nxt = prev_r;
        seen_nxt  = (seen_r == 2'd2) ? 2'd2 : seen_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_order_r <= ecgdh_pkg::ORDER_RAW;
      prev_r       <= '0;
      pprev_r      <= '0;
      seen_r       <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        diff_order_r <= cfg_wr_data;
      end
      prev_r  <= prev_nxt;
      pprev_r <= pprev_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecgdh_fifo.sv @@
// Short queue of classified codes between front and packer.
// Depends on ecgdh_pkg.
`default_nettype none

module ecgdh_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push_valid,
  output logic                        push_ready,
  input  wire ecgdh_pkg::code_entry_t push_data,
  output logic                        pop_valid,
  input  wire logic                   pop_ready,
  output ecgdh_pkg::code_entry_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ecgdh_pkg::code_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecgdh_pack.sv @@
// Back end: bit packer, merges codes with carried bits and emits one byte a beat.
// Depends on ecgdh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ecgdh_pack (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  wire ecgdh_pkg::code_entry_t pop_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ecgdh_pkg::out_item_t        out_data
);

  localparam int ACC_W  = ecgdh_pkg::ACC_W;
  localparam int CNT_W  = ecgdh_pkg::CNT_W;
  localparam int PEND_W = ecgdh_pkg::PEND_W;

  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_w;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_w;
  logic              last_pend_r, last_pend_nxt, last_w;
  logic              out_valid_r, out_valid_nxt;
  ecgdh_pkg::out_item_t out_r, out_nxt;
  logic [PEND_W-1:0] pend_mask;
  logic [ACC_W-1:0]  pend;
  logic [ACC_W-1:0]  shifted;
  logic [7:0]        pad_byte;
  logic              can_emit, load;
  logic              emit_last;

  assign can_emit  = !out_valid_r || out_ready;
  assign load      = can_emit && (cnt_r < CNT_W'(8)) && !last_pend_r && pop_valid;
  assign pop_ready = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    // only the low cnt_r bits are meaningful while loading
    pend_mask = ~({PEND_W{1'b1}} << cnt_r[2:0]);
    pend      = {{(ACC_W-PEND_W){1'b0}}, acc_r[PEND_W-1:0] & pend_mask};
    if (load) begin
      acc_w  = (pend << pop_data.len) | {{(ACC_W-ecgdh_pkg::CODE_W){1'b0}}, pop_data.code};
      cnt_w  = cnt_r + {1'b0, pop_data.len};
      last_w = pop_data.last;
    end else begin
      acc_w  = acc_r;
      cnt_w  = cnt_r;
      last_w = last_pend_r;
    end
    shifted  = acc_w >> (cnt_w - CNT_W'(8));
    pad_byte = acc_w[7:0] << (CNT_W'(8) - cnt_w);

    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    last_pend_nxt = last_pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    emit_last     = 1'b0;
    if (can_emit) begin
      acc_nxt = acc_w;
      if (cnt_w >= CNT_W'(8)) begin
        cnt_nxt           = cnt_w - CNT_W'(8);
        last_pend_nxt     = last_w;
        out_valid_nxt     = 1'b1;
        out_nxt.out_byte  = shifted[7:0];
        out_nxt.last_byte = 1'b0;
      end else if (last_w) begin
        // flush: pad partial byte with zeros, or a zero byte when aligned
        acc_nxt           = '0;
        cnt_nxt           = '0;
        last_pend_nxt     = 1'b0;
        out_valid_nxt     = 1'b1;
        out_nxt.out_byte  = (cnt_w == '0) ? 8'h00 : pad_byte;
        out_nxt.last_byte = 1'b1;
        emit_last         = 1'b1;
      end else begin
        cnt_nxt       = cnt_w;
        last_pend_nxt = 1'b0;
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(25))
  `ASSERT_IMPLIES(a_load_drained, clk, rst_n, pop_ready, cnt_r < CNT_W'(8) && !last_pend_r)
  `ASSERT_NEXT(a_flush_clears, clk, rst_n, emit_last, cnt_r == '0 && !last_pend_r)

endmodule

`default_nettype wire

@@ rtl/ecg_default_huffman_encoder.sv @@
// Path: a sample is classified combinationally, stored in the queue, and its first byte is
// registered in the packer's output register. Intake: one sample a cycle into a QUEUE_DEPTH-entry
// queue while it is not full; the packer emits one byte a cycle while out_ready allows it.
// The packer's one-byte-per-cycle output register sets the sustained rate.
// Reset (rst_n low, synchronous): diff_order to raw, history, queue and carried bits cleared.
`default_nettype none

module ecg_default_huffman_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ecgdh_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ecgdh_pkg::out_item_t      out_data
);

  logic                   push_valid, push_ready;
  ecgdh_pkg::code_entry_t push_data;
  logic                   pop_valid, pop_ready;
  ecgdh_pkg::code_entry_t pop_data;

  ecgdh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  ecgdh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ecgdh_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ test/tb_ecg_default_huffman_encoder.sv @@
// Self-checking testbench for ecg_default_huffman_encoder: directed and random samples,
// with every code byte checked against a local encoder and packer model.
// Depends on ecgdh_pkg and the encoder RTL.
`default_nettype none

module tb_ecg_default_huffman_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ORDER_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 300000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ecgdh_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ecgdh_pkg::out_item_t out_data;

  ecg_default_huffman_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expected bytes
  ecgdh_pkg::in_item_t  sample_q[$];
  ecgdh_pkg::out_item_t coded_bytes_q[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        n_pushed = 0;
  int        n_accepted = 0;
  int        n_checked = 0;
  int        n_leads = 0;
  int        n_errors = 0;
  int        cycles = 0;

  // encoder model state
  logic [1:0] order_q = ecgdh_pkg::ORDER_RAW;
  int         hist1 = 0;
  int         hist2 = 0;
  int         seen = 0;
  logic [6:0] carry_bits = '0;
  int         carry_cnt = 0;

  // generator's own view of the lead, to aim differences
  int         gen1 = 0;
  int         gen2 = 0;
  int         gen_seen = 0;

  task automatic encode_sample(input ecgdh_pkg::in_item_t it);
    int                 s;
    int                 d;
    int                 m;
    int                 len;
    int                 cnt;
    logic signed [15:0] dv;
    logic [25:0]        code;
    logic [32:0]        acc;
    logic [32:0]        tmp;
    ecgdh_pkg::out_item_t r;
    s = $signed(it.sample);
    if (order_q == ecgdh_pkg::ORDER_FIRST && seen >= 1) begin
      d = s - hist1;
    end else if (order_q == ecgdh_pkg::ORDER_SECOND && seen >= 2) begin
      d = s - 2 * hist1 + hist2;
    end else begin
      d = s;
    end
    dv = d[15:0];
    if (dv == 16'sh8000) dv = 16'sh7FFF;

    if (dv == 0) begin
      code = '0;
      len = 1;
    end else if (dv >= -8 && dv <= 8) begin
      m = (dv < 0) ? -int'(dv) : int'(dv);
      code = (((26'd1 << m) - 26'd1) << 2) | {25'd0, dv < 0};
      len = m + 2;
    end else if (dv > 127 || dv < -128) begin
      code = {9'h1FF, 1'b1, dv};
      len = 26;
    end else begin
      code = {8'd0, 9'h1FF, 1'b0, dv[7:0]};
      len = 18;
    end

    acc = ({26'd0, carry_bits} << len) | {7'd0, code};
    cnt = carry_cnt + len;
    while (cnt >= 8) begin
      tmp = acc >> (cnt - 8);
      r.out_byte = tmp[7:0];
      r.last_byte = 1'b0;
      coded_bytes_q.push_back(r);
      cnt -= 8;
    end
    acc = acc & ((33'd1 << cnt) - 33'd1);

    if (it.end_of_block) begin
      // zero-pad the tail; an aligned stream still gets one closing 0x00 byte
      tmp = acc << (8 - cnt);
      r.out_byte = (cnt > 0) ? tmp[7:0] : 8'h00;
      r.last_byte = 1'b1;
      coded_bytes_q.push_back(r);
      n_leads++;
      hist1 = 0;
      hist2 = 0;
      seen = 0;
      carry_bits = '0;
      carry_cnt = 0;
    end else begin
      carry_bits = acc[6:0];
      carry_cnt = cnt;
      hist2 = hist1;
      hist1 = s;
      if (seen < 2) seen++;
    end
  endtask

  // driver: one beat at a time from sample_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_sample(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (coded_bytes_q.size() == 0) begin
          $error("unexpected beat: out_byte %02h last_byte %0b",
                 out_data.out_byte, out_data.last_byte);
          n_errors++;
        end else begin
          ecgdh_pkg::out_item_t want;
          want = coded_bytes_q.pop_front();
          n_checked++;
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, out_data.out_byte);
            n_errors++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, out_data.last_byte);
            n_errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, coded_bytes_q.size());
      $display("tb_ecg_default_huffman_encoder: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (n_accepted != n_pushed || coded_bytes_q.size() != 0) @(posedge clk);
    // a sample that completes no byte may still sit in the encoder queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_order(input logic [1:0] ord);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ord;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_q = ord;
  endtask

  task automatic push_sample(input logic signed [15:0] v, input logic eob);
    ecgdh_pkg::in_item_t it;
    it.sample = v;
    it.end_of_block = eob;
    sample_q.push_back(it);
    n_pushed++;
  endtask

  // mostly samples aimed at a chosen difference class, some plain noise
  task automatic push_random(input logic [1:0] ord);
    int   base;
    int   delta;
    int   s;
    int   cat;
    logic eob;
    if (ord == ecgdh_pkg::ORDER_FIRST && gen_seen >= 1) begin
      base = gen1;
    end else if (ord == ecgdh_pkg::ORDER_SECOND && gen_seen >= 2) begin
      base = 2 * gen1 - gen2;
    end else begin
      base = 0;
    end
    cat = $urandom_range(9);
    case (cat) inside
      0, 1: begin
        delta = 0;
      end
      [2:5]: begin
        delta = $urandom_range(1, 8);
        if ($urandom_range(1) != 0) delta = -delta;
      end
      [6:7]: begin
        delta = $urandom_range(9, 127);
        if ($urandom_range(1) != 0) delta = -delta;
        if ($urandom_range(7) == 0) delta = -128;
      end
      default: begin
        delta = $signed(16'($urandom));
      end
    endcase
    s = (cat == 9) ? int'($signed(16'($urandom))) : base + delta;
    s = $signed(s[15:0]);
    eob = ($urandom_range(9) == 0);
    push_sample(s[15:0], eob);
    if (eob) begin
      gen1 = 0;
      gen2 = 0;
      gen_seen = 0;
    end else begin
      gen2 = gen1;
      gen1 = s;
      if (gen_seen < 2) gen_seen++;
    end
  endtask

  task automatic run_phase(input logic [1:0] ord, input int n_items);
    wait_drained();
    set_order(ord);
    for (int i = 0; i < n_items; i++) begin
      // hold the sender until the encoder has caught up
      if (i == n_items / 2) wait_drained();
      push_random(ord);
    end
  endtask

  initial begin
    logic [1:0] orders[4];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 58;

    // raw codes across every size class, most negative value folded to max
    set_order(ecgdh_pkg::ORDER_RAW);
    push_sample(0, 0);
    push_sample(1, 0);
    push_sample(-1, 0);
    push_sample(8, 0);
    push_sample(-8, 0);
    push_sample(9, 0);
    push_sample(-128, 0);
    push_sample(128, 0);
    push_sample(32767, 0);
    push_sample(-32768, 1);
    // 3 + 5 bits: aligned end, extra closing byte
    push_sample(1, 0);
    push_sample(3, 1);
    wait_drained();

    // first difference: start of lead, zero, wrap to most negative
    set_order(ecgdh_pkg::ORDER_FIRST);
    push_sample(16384, 0);
    push_sample(16384, 0);
    push_sample(-16384, 0);
    push_sample(-16380, 1);
    // order change mid-lead: history carries into second order
    push_sample(5, 0);
    push_sample(10, 0);
    wait_drained();
    set_order(ecgdh_pkg::ORDER_SECOND);
    push_sample(15, 0);
    push_sample(21, 1);
    wait_drained();
    set_order(ORDER_UNUSED);
    push_sample(7, 0);
    push_sample(-7, 1);
    wait_drained();

    gen1 = 0;
    gen2 = 0;
    gen_seen = 0;
    orders = '{ecgdh_pkg::ORDER_SECOND, ecgdh_pkg::ORDER_RAW, ORDER_UNUSED,
               ecgdh_pkg::ORDER_FIRST};
    for (int r = 0; r < 3; r++) begin
      send_idle_pct = (r == 0) ? 10 : (r == 1) ? 58 : 0;
      recv_idle_pct = (r == 0) ? 58 : (r == 1) ? 10 : 0;
      for (int k = 0; k < 4; k++) run_phase(orders[(k + r) % 4], 17);
    end
    push_sample(16'($urandom), 1);
    wait_drained();

    $display("covered %0d samples in %0d closed leads, %0d code bytes checked,",
             n_accepted, n_leads, n_checked);
    $display("all four diff_order settings under three handshake pacing modes");
    if (n_errors == 0) begin
      $display("tb_ecg_default_huffman_encoder: PASS");
    end else begin
      $display("tb_ecg_default_huffman_encoder: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
